// ----- rtl/hsg_pkg.sv -----
// Shared types, constants and lookup tables of the hue sector glyph classifier.
`timescale 1ns / 1ps

package hsg_pkg;

    // Which component won the maximum (red first, then green, then blue)
    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    localparam logic [7:0]  THRESHOLD_RESET = 8'd51;

    // Luminance weights, scaled by 10000
    localparam logic [20:0] LUM_COEF_R = 21'd2987;
    localparam logic [20:0] LUM_COEF_G = 21'd5870;
    localparam logic [20:0] LUM_COEF_B = 21'd1140;
    localparam logic [24:0] GREY_LEVELS = 25'd13;
    // One grey level step of 13*lum: 10000 * 255
    localparam int          GREY_STEP   = 2550000;
    localparam int          GREY_MAX    = 12;

    localparam logic [5:0]  SECTOR_COUNT  = 6'd24;
    localparam logic [5:0]  SECTOR_OFFSET = 6'd20;

    typedef struct packed {
        logic [1:0] glyph;
        logic [3:0] fg;
        logic [3:0] bg;
    } cell_t;

    // After the extremes stage
    typedef struct packed {
        logic [7:0]        mx;
        logic [7:0]        mn;
        logic [1:0]        sel;
        logic signed [8:0] diff;
        logic [20:0]       prod_r;
        logic [20:0]       prod_g;
        logic [20:0]       prod_b;
    } extreme_t;

    // After the saturation stage
    typedef struct packed {
        logic        coloured;
        logic [1:0]  sel;
        logic [7:0]  delta;
        logic [10:0] dividend;
        logic [21:0] lum;
    } front_t;

    // After the first division stage
    typedef struct packed {
        logic        coloured;
        logic [1:0]  sel;
        logic [7:0]  delta;
        logic [10:0] rem;
        logic [1:0]  quot_hi;
        logic [24:0] lum13;
    } div_half_t;

    // After the second division stage
    typedef struct packed {
        logic       coloured;
        logic [1:0] sel;
        logic [3:0] quot;
        logic [3:0] level;
    } div_t;

    function automatic cell_t hue_cell(input logic [4:0] sector);
        cell_t c;
        c.glyph = sector[1:0];
        case (sector[4:2])
            3'd0:    begin c.fg = 4'd12; c.bg = 4'd12; end
            3'd1:    begin c.fg = 4'd10; c.bg = 4'd14; end
            3'd2:    begin c.fg = 4'd11; c.bg = 4'd10; end
            3'd3:    begin c.fg = 4'd9;  c.bg = 4'd11; end
            3'd4:    begin c.fg = 4'd13; c.bg = 4'd9;  end
            3'd5:    begin c.fg = 4'd12; c.bg = 4'd13; end
            default: begin c.fg = 4'd12; c.bg = 4'd12; end
        endcase
        // first sector of the red band keeps red on red
        if (sector == 5'd0) begin
            c.fg = 4'd12;
        end
        if (sector[4:2] == 3'd0 && sector[1:0] != 2'd0) begin
            c.fg = 4'd14;
        end
        return c;
    endfunction

    function automatic cell_t grey_cell(input logic [3:0] level);
        cell_t c;
        c.glyph = level[1:0];
        case (level)
            4'd0:                      begin c.fg = 4'd0;  c.bg = 4'd0; end
            4'd1, 4'd2, 4'd3, 4'd4:    begin c.fg = 4'd8;  c.bg = 4'd0; end
            4'd5, 4'd6, 4'd7, 4'd8:    begin c.fg = 4'd7;  c.bg = 4'd8; end
            4'd9, 4'd10, 4'd11, 4'd12: begin c.fg = 4'd15; c.bg = 4'd7; end
            default:                   begin c.fg = 4'd15; c.bg = 4'd7; end
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/hsg_front.sv -----
// Extremes and saturation stages: max, min, hue difference, luminance, coloured test.
`timescale 1ns / 1ps

module hsg_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic [7:0]            threshold,
    output logic                  out_valid,
    input  logic                  out_ready,
    output hsg_pkg::front_t       out_data
);

    hsg_pkg::extreme_t ext_next, ext_reg;
    hsg_pkg::front_t   frt_next, frt_reg;
    logic              ext_valid_reg, frt_valid_reg;
    logic              ext_ready, frt_ready;

    logic [7:0]         mx_rg, mn_rg;
    logic [15:0]        sat_lhs, sat_rhs;
    logic [7:0]         delta;
    logic signed [11:0] dividend_s;

    assign frt_ready = !frt_valid_reg || out_ready;
    assign ext_ready = !ext_valid_reg || frt_ready;
    assign in_ready  = ext_ready;

    always_comb begin
        mx_rg = (red > green) ? red : green;
        mn_rg = (red < green) ? red : green;
        ext_next.mx = (mx_rg > blue) ? mx_rg : blue;
        ext_next.mn = (mn_rg < blue) ? mn_rg : blue;
        if (red >= ext_next.mx) begin
            ext_next.sel  = hsg_pkg::SEL_RED;
            ext_next.diff = $signed({1'b0, green}) - $signed({1'b0, blue});
        end else if (green >= ext_next.mx) begin
            ext_next.sel  = hsg_pkg::SEL_GREEN;
            ext_next.diff = $signed({1'b0, blue}) - $signed({1'b0, red});
        end else begin
            ext_next.sel  = hsg_pkg::SEL_BLUE;
            ext_next.diff = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        ext_next.prod_r = 21'(red)   * hsg_pkg::LUM_COEF_R;
        ext_next.prod_g = 21'(green) * hsg_pkg::LUM_COEF_G;
        ext_next.prod_b = 21'(blue)  * hsg_pkg::LUM_COEF_B;
    end

    always_comb begin
        delta   = ext_reg.mx - ext_reg.mn;
        sat_lhs = {delta, 8'd0} - 16'(delta);
        sat_rhs = 16'(threshold) * 16'(ext_reg.mx);
        // shift the hue by four sectors so the dividend stays non-negative
        dividend_s = (12'(ext_reg.diff) <<< 2) + $signed({2'b00, delta, 2'b00});
        frt_next.coloured = (delta != 8'd0) && (sat_lhs > sat_rhs);
        frt_next.sel      = ext_reg.sel;
        frt_next.delta    = delta;
        frt_next.dividend = dividend_s[10:0];
        frt_next.lum      = 22'(ext_reg.prod_r) + 22'(ext_reg.prod_g)
                          + 22'(ext_reg.prod_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_valid_reg <= 1'b0;
            frt_valid_reg <= 1'b0;
        end else begin
            if (ext_ready) begin
                ext_valid_reg <= in_valid;
            end
            if (frt_ready) begin
                frt_valid_reg <= ext_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ext_ready && in_valid) begin
            ext_reg <= ext_next;
        end
        if (frt_ready && ext_valid_reg) begin
            frt_reg <= frt_next;
        end
    end

    assign out_valid = frt_valid_reg;
    assign out_data  = frt_reg;

endmodule

// ----- rtl/hsg_divide.sv -----
// Two-stage restoring divider for the hue quotient, plus the grey level search.
`timescale 1ns / 1ps

module hsg_divide (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hsg_pkg::front_t       in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output hsg_pkg::div_t         out_data
);

    hsg_pkg::div_half_t half_next, half_reg;
    hsg_pkg::div_t      div_next, div_reg;
    logic               half_valid_reg, div_valid_reg;
    logic               half_ready, div_ready;

    logic [10:0] rem_a, rem_b;
    logic [10:0] step3, step2, step1, step0;
    logic        q3, q2, q1, q0;

    assign div_ready  = !div_valid_reg || out_ready;
    assign half_ready = !half_valid_reg || div_ready;
    assign in_ready   = half_ready;

    // quotient bits 3 and 2
    always_comb begin
        step3 = {in_data.delta, 3'd0};
        step2 = {1'b0, in_data.delta, 2'd0};
        q3    = in_data.dividend >= step3;
        rem_a = q3 ? (in_data.dividend - step3) : in_data.dividend;
        q2    = rem_a >= step2;
        half_next.rem      = q2 ? (rem_a - step2) : rem_a;
        half_next.quot_hi  = {q3, q2};
        half_next.coloured = in_data.coloured;
        half_next.sel      = in_data.sel;
        half_next.delta    = in_data.delta;
        half_next.lum13    = 25'(in_data.lum) * hsg_pkg::GREY_LEVELS;
    end

    // quotient bits 1 and 0, grey level by threshold compares
    always_comb begin
        step1 = {2'd0, half_reg.delta, 1'b0};
        step0 = {3'd0, half_reg.delta};
        q1    = half_reg.rem >= step1;
        rem_b = q1 ? (half_reg.rem - step1) : half_reg.rem;
        q0    = rem_b >= step0;
        div_next.quot     = {half_reg.quot_hi, q1, q0};
        div_next.coloured = half_reg.coloured;
        div_next.sel      = half_reg.sel;
        div_next.level    = 4'd0;
        for (int k = 1; k <= hsg_pkg::GREY_MAX; k++) begin
            if (half_reg.lum13 >= 25'(k * hsg_pkg::GREY_STEP)) begin
                div_next.level = 4'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_valid_reg <= 1'b0;
            div_valid_reg  <= 1'b0;
        end else begin
            if (half_ready) begin
                half_valid_reg <= in_valid;
            end
            if (div_ready) begin
                div_valid_reg <= half_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (half_ready && in_valid) begin
            half_reg <= half_next;
        end
        if (div_ready && half_valid_reg) begin
            div_reg <= div_next;
        end
    end

    assign out_valid = div_valid_reg;
    assign out_data  = div_reg;

endmodule

// ----- rtl/hsg_lookup.sv -----
// Output stage: hue sector wrap, table lookup and the result register.
`timescale 1ns / 1ps

module hsg_lookup (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  hsg_pkg::div_t         in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output hsg_pkg::cell_t        out_cell,
    output logic                  out_coloured
);

    hsg_pkg::cell_t cell_next, cell_reg;
    logic           coloured_reg;
    logic           valid_reg;
    logic           ready;
    logic [5:0]     seg_base, sector_raw, sector;

    assign ready    = !valid_reg || out_ready;
    assign in_ready = ready;

    always_comb begin
        case (in_data.sel)
            hsg_pkg::SEL_RED:   seg_base = 6'd0;
            hsg_pkg::SEL_GREEN: seg_base = 6'd8;
            hsg_pkg::SEL_BLUE:  seg_base = 6'd16;
            default:            seg_base = 6'd0;
        endcase
        // undo the four-sector shift of the dividend, modulo 24
        sector_raw = seg_base + 6'(in_data.quot) + hsg_pkg::SECTOR_OFFSET;
        sector     = (sector_raw >= hsg_pkg::SECTOR_COUNT)
                   ? (sector_raw - hsg_pkg::SECTOR_COUNT) : sector_raw;
        cell_next  = in_data.coloured ? hsg_pkg::hue_cell(sector[4:0])
                                      : hsg_pkg::grey_cell(in_data.level);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready && in_valid) begin
            cell_reg     <= cell_next;
            coloured_reg <= in_data.coloured;
        end
    end

    assign out_valid    = valid_reg;
    assign out_cell     = cell_reg;
    assign out_coloured = coloured_reg;

endmodule

// ----- rtl/hue_sector_glyph_classifier.sv -----
// Top level: RGB pixel stream in, text-mode cell stream out.
// Throughput: one pixel per cycle while m_tready holds; five register stages, each with its own valid bit.
// Backpressure empties only as far as the first free stage, so s_tready stays high
// while any stage of the pipeline holds a bubble.
// Reset (aresetn low, synchronous): all stages empty, saturation_threshold back to 51.
`timescale 1ns / 1ps

module hue_sector_glyph_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    // pixel in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    // cell out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [1:0] glyph, [5:2] fg_colour, [9:6] bg_colour, rest 0
    output logic [0:0]  m_tuser,   // [0] coloured
    // saturation_threshold write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic [7:0] threshold_reg;

    hsg_pkg::front_t front_data;
    hsg_pkg::div_t   div_data;
    hsg_pkg::cell_t  lookup_cell;
    logic            front_valid, front_ready;
    logic            div_valid, div_ready;
    logic            coloured;

    // Threshold register: writes always accepted; user must change it only while idle; not enforced
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= hsg_pkg::THRESHOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            threshold_reg <= cfg_data;
        end
    end

    // Stages 1-2: extremes, luminance products, coloured test
    hsg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .threshold (threshold_reg),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    // Stages 3-4: hue quotient two bits per stage, grey level compares
    hsg_divide u_divide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    // Stage 5: sector wrap, table lookup, output register
    hsg_lookup u_lookup (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (div_valid),
        .in_ready     (div_ready),
        .in_data      (div_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_cell     (lookup_cell),
        .out_coloured (coloured)
    );

    assign m_tdata    = {6'd0, lookup_cell.bg, lookup_cell.fg, lookup_cell.glyph};
    assign m_tuser[0] = coloured;

`ifndef SYNTH
    // Input stalls only when every stage is full and the output is blocked
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("s_tready low while the pipeline has room");

    // Hue cells use only the bright colours 9 to 14
    a_hue_colours: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[5:2] >= 4'd9 && m_tdata[5:2] <= 4'd14
                                      && m_tdata[9:6] >= 4'd9 && m_tdata[9:6] <= 4'd14))
        else $error("coloured cell with a non-hue colour");

    // Grey cells keep a grey or black background
    a_grey_background: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[9:6] == 4'd0 || m_tdata[9:6] == 4'd7
                                       || m_tdata[9:6] == 4'd8))
        else $error("grey cell with a coloured background");
`endif

endmodule

// ----- sim/hue_sector_glyph_classifier_tb.sv -----
// Self-checking testbench of the hue sector glyph classifier: stream stimulus, cell prediction.
`timescale 1ns / 1ps

module hue_sector_glyph_classifier_tb;

    // Pipeline depth given at the head of the top level
    localparam int PIPE_LATENCY   = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PIXELS  = 1680;
    localparam int RANDOM_PHASES  = 6;

    localparam logic [7:0] THRESHOLD_AT_RESET = 8'd51;

    // Shade glyphs
    localparam logic [1:0] GLY_SOLID   = 2'd0;
    localparam logic [1:0] GLY_QUARTER = 2'd1;
    localparam logic [1:0] GLY_HALF    = 2'd2;
    localparam logic [1:0] GLY_THREE_Q = 2'd3;

    // Console palette entries used by the tables
    localparam logic [3:0] COL_BLACK     = 4'd0;
    localparam logic [3:0] COL_GREY      = 4'd7;
    localparam logic [3:0] COL_DARK_GREY = 4'd8;
    localparam logic [3:0] COL_BLUE      = 4'd9;
    localparam logic [3:0] COL_GREEN     = 4'd10;
    localparam logic [3:0] COL_CYAN      = 4'd11;
    localparam logic [3:0] COL_RED       = 4'd12;
    localparam logic [3:0] COL_MAGENTA   = 4'd13;
    localparam logic [3:0] COL_YELLOW    = 4'd14;
    localparam logic [3:0] COL_WHITE     = 4'd15;

    typedef struct packed {
        logic [1:0] glyph;
        logic [3:0] fg;
        logic [3:0] bg;
        logic       coloured;
    } char_cell_t;

    typedef struct {
        logic [23:0] pixel;
        char_cell_t  exp_cell;
    } pending_cell_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [7:0] red, [15:8] green, [23:16] blue
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [1:0] glyph, [5:2] fg_colour, [9:6] bg_colour, rest 0
    logic [0:0]  m_tuser;    // [0] coloured
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    // Predictor state: the threshold as last written
    logic [7:0]    sat_threshold;
    pending_cell_t cell_expect_q[$];

    // Traffic shaping knobs, set by the tests
    bit tx_throttle;
    bit rx_throttle;
    int rx_hold_req;

    // Run statistics
    int mismatches;
    int cells_checked;
    int coloured_seen;
    int grey_seen;
    int thresholds_written;
    int input_stall_cycles;
    int idle_cycles;

    hue_sector_glyph_classifier u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Cell predictor
    // ------------------------------------------------------------------

    // Glyphs cycle solid, quarter, half, three-quarter through every band
    function automatic logic [1:0] shade_of(input int step);
        case (step % 4)
            0:       return GLY_SOLID;
            1:       return GLY_QUARTER;
            2:       return GLY_HALF;
            default: return GLY_THREE_Q;
        endcase
    endfunction

    function automatic char_cell_t hue_sector_cell(input int sector);
        char_cell_t c;
        c.glyph    = shade_of(sector);
        c.coloured = 1'b1;
        case (sector / 4)
            0: begin
                // red on red only in the very first sector, yellow after
                c.fg = (sector == 0) ? COL_RED : COL_YELLOW;
                c.bg = COL_RED;
            end
            1:       begin c.fg = COL_GREEN;   c.bg = COL_YELLOW;  end
            2:       begin c.fg = COL_CYAN;    c.bg = COL_GREEN;   end
            3:       begin c.fg = COL_BLUE;    c.bg = COL_CYAN;    end
            4:       begin c.fg = COL_MAGENTA; c.bg = COL_BLUE;    end
            default: begin c.fg = COL_RED;     c.bg = COL_MAGENTA; end
        endcase
        return c;
    endfunction

    function automatic char_cell_t grey_level_cell(input int level);
        char_cell_t c;
        c.glyph    = shade_of(level);
        c.coloured = 1'b0;
        // level 0 is black alone, then bands of four levels each
        case ((level + 3) / 4)
            0:       begin c.fg = COL_BLACK;     c.bg = COL_BLACK;     end
            1:       begin c.fg = COL_DARK_GREY; c.bg = COL_BLACK;     end
            2:       begin c.fg = COL_GREY;      c.bg = COL_DARK_GREY; end
            default: begin c.fg = COL_WHITE;     c.bg = COL_GREY;      end
        endcase
        return c;
    endfunction

    function automatic char_cell_t classify_pixel(input logic [23:0] pixel,
                                                  input logic [7:0]  thr);
        int r;
        int g;
        int b;
        int mx;
        int mn;
        int delta;
        int seg;
        int diff;
        int sector;
        int lum;
        int level;
        r  = int'(pixel[7:0]);
        g  = int'(pixel[15:8]);
        b  = int'(pixel[23:16]);
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        delta = mx - mn;
        if (delta != 0 && delta * 255 > int'(thr) * mx) begin
            // red wins ties, then green
            if (r >= mx) begin
                seg  = 0;
                diff = g - b;
            end else if (g >= mx) begin
                seg  = 2;
                diff = b - r;
            end else begin
                seg  = 4;
                diff = r - g;
            end
            // shift up by a full turn so the floor division sees a positive value
            sector = ((4 * (seg * delta + diff) + 24 * delta) / delta) % 24;
            return hue_sector_cell(sector);
        end
        lum   = 2987 * r + 5870 * g + 1140 * b;
        level = (13 * lum) / 2550000;
        if (level > 12) begin
            level = 12;
        end
        return grey_level_cell(level);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, a few long ones
    function automatic int traffic_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [23:0] pack_pixel(input int r, input int g, input int b);
        return {b[7:0], g[7:0], r[7:0]};
    endfunction

    // Random pixel biased toward the saturation boundary, ties and greys
    function automatic logic [23:0] random_pixel(input logic [7:0] thr);
        int kind;
        int mx;
        int mn;
        int delta;
        int ch[3];
        int i_max;
        int i_min;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            return 24'($urandom);
        end
        mx    = $urandom_range(1, 255);
        i_max = $urandom_range(0, 2);
        i_min = (i_max + $urandom_range(1, 2)) % 3;
        if (kind < 7) begin
            // land on either side of delta * 255 == thr * max
            delta = (int'(thr) * mx) / 255 + $urandom_range(0, 2) - 1;
            if (delta < 0) begin
                delta = 0;
            end
            if (delta > mx) begin
                delta = mx;
            end
            mn = mx - delta;
            ch[i_max] = mx;
            ch[i_min] = mn;
            ch[3 - i_max - i_min] = $urandom_range(mn, mx);
        end else if (kind < 9) begin
            // two components share the maximum
            mn = $urandom_range(0, mx);
            ch[0] = mx;
            ch[1] = mx;
            ch[2] = mx;
            ch[i_min] = mn;
        end else begin
            ch[0] = $urandom_range(0, 255);
            ch[1] = ch[0];
            ch[2] = ch[0];
        end
        return pack_pixel(ch[0], ch[1], ch[2]);
    endfunction

    // Offer one pixel; call at a falling edge, returns at a falling edge with
    // s_tvalid still high, so back-to-back transactions follow without a gap.
    task automatic send_pixel(input logic [23:0] pixel);
        int gap;
        pending_cell_t entry;
        gap = 0;
        if (tx_throttle && $urandom_range(0, 99) < 40) begin
            gap = traffic_gap();
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        entry.pixel    = pixel;
        entry.exp_cell = classify_pixel(pixel, sat_threshold);
        cell_expect_q.push_back(entry);
        @(negedge aclk);
    endtask

    // Stop offering and hold until every pending cell has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (cell_expect_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_threshold(input logic [7:0] value);
        wait_drained();
        // let the last cells clear the pipeline before touching the register
        repeat (PIPE_LATENCY + 2) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        sat_threshold = value;
        thresholds_written++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset threshold: extremes, primaries, max ties, hue wrap, the
    // saturation boundary and the grey ramp ends
    task automatic test_directed_corners();
        tx_throttle = 1'b0;
        rx_throttle = 1'b0;
        send_pixel(pack_pixel(0, 0, 0));           // black, zero max
        send_pixel(pack_pixel(255, 255, 255));     // white, top grey level
        send_pixel(pack_pixel(255, 0, 0));
        send_pixel(pack_pixel(0, 255, 0));
        send_pixel(pack_pixel(0, 0, 255));
        send_pixel(pack_pixel(255, 255, 0));       // red beats green on a tie
        send_pixel(pack_pixel(0, 255, 255));       // green beats blue on a tie
        send_pixel(pack_pixel(255, 0, 255));       // red beats blue on a tie
        send_pixel(pack_pixel(255, 0, 10));        // negative hue wraps to the top sector
        send_pixel(pack_pixel(200, 40, 180));
        send_pixel(pack_pixel(10, 0, 255));
        send_pixel(pack_pixel(0, 10, 255));
        send_pixel(pack_pixel(255, 204, 204));     // delta*255 equals thr*max: grey
        send_pixel(pack_pixel(255, 203, 203));     // one step past: coloured
        send_pixel(pack_pixel(1, 0, 0));           // smallest coloured pixel
        send_pixel(pack_pixel(0, 0, 1));
        send_pixel(pack_pixel(128, 128, 128));
        send_pixel(pack_pixel(85, 85, 85));
        send_pixel(pack_pixel(8'h55, 8'hAA, 8'h55));
        send_pixel(pack_pixel(8'hAA, 8'h55, 8'hAA));
        send_pixel(pack_pixel(254, 254, 254));
    endtask

    // Threshold 0 colours everything with spread, 255 colours nothing
    task automatic test_threshold_extremes();
        write_threshold(8'd0);
        send_pixel(pack_pixel(255, 254, 254));
        send_pixel(pack_pixel(1, 1, 0));
        send_pixel(pack_pixel(77, 77, 77));
        repeat (6) send_pixel(random_pixel(sat_threshold));
        write_threshold(8'd255);
        send_pixel(pack_pixel(255, 0, 0));
        send_pixel(pack_pixel(0, 0, 255));
        send_pixel(pack_pixel(255, 254, 254));
        repeat (6) send_pixel(random_pixel(sat_threshold));
    endtask

    // Stall the output long enough that the pipeline fills and s_tready drops
    task automatic test_output_stall_fill();
        write_threshold(8'd128);
        tx_throttle = 1'b0;
        rx_throttle = 1'b0;
        rx_hold_req = 80;
        repeat (40) send_pixel(random_pixel(sat_threshold));
    endtask

    // Sender pauses until the block is empty, then resumes
    task automatic test_sender_drain_pause();
        tx_throttle = 1'b1;
        rx_throttle = 1'b1;
        repeat (30) send_pixel(random_pixel(sat_threshold));
        wait_drained();
        repeat (30) send_pixel(random_pixel(sat_threshold));
    endtask

    // Bulk random traffic over several thresholds; one phase runs without gaps
    task automatic test_random_traffic();
        logic [7:0] thr;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       thr = THRESHOLD_AT_RESET;
                1:       thr = 8'd0;
                2:       thr = 8'd255;
                3:       thr = 8'd1;
                4:       thr = 8'd254;
                default: thr = 8'($urandom_range(2, 253));
            endcase
            write_threshold(thr);
            tx_throttle = (phase != 3);
            rx_throttle = (phase != 3);
            repeat (RANDOM_PIXELS / RANDOM_PHASES) send_pixel(random_pixel(sat_threshold));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        sat_threshold = THRESHOLD_AT_RESET;
        tx_throttle   = 1'b0;
        rx_throttle   = 1'b0;
        rx_hold_req   = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_corners();
        test_threshold_extremes();
        test_output_stall_fill();
        test_sender_drain_pause();
        test_random_traffic();

        wait_drained();
        // watch for stray cells after the last expected one
        repeat (PIPE_LATENCY * 4) @(negedge aclk);

        $display("Checked %0d cells (%0d coloured, %0d grey) under %0d threshold writes.",
                 cells_checked, coloured_seen, grey_seen, thresholds_written);
        $display("Input was held off for %0d cycles by output backpressure; %0d mismatches.",
                 input_stall_cycles, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold when a test asks for one
    // ------------------------------------------------------------------

    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req > 0) begin
                rx_hold_req--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (rx_throttle && $urandom_range(0, 99) < 30) begin
                stall_left = traffic_gap() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        pending_cell_t exp_entry;
        char_cell_t    got;
        if (aresetn && m_tvalid && m_tready) begin
            got.glyph    = m_tdata[1:0];
            got.fg       = m_tdata[5:2];
            got.bg       = m_tdata[9:6];
            got.coloured = m_tuser[0];
            if (cell_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("[%0t] unexpected cell glyph=%0d fg=%0d bg=%0d coloured=%0d",
                             $realtime, got.glyph, got.fg, got.bg, got.coloured);
                end
            end else begin
                exp_entry = cell_expect_q.pop_front();
                cells_checked++;
                if (exp_entry.exp_cell.coloured) begin
                    coloured_seen++;
                end else begin
                    grey_seen++;
                end
                if (got !== exp_entry.exp_cell) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display({"[%0t] pixel b/g/r=%h: exp glyph=%0d fg=%0d bg=%0d col=%0d,",
                                  " got glyph=%0d fg=%0d bg=%0d col=%0d"},
                                 $realtime, exp_entry.pixel,
                                 exp_entry.exp_cell.glyph, exp_entry.exp_cell.fg,
                                 exp_entry.exp_cell.bg, exp_entry.exp_cell.coloured,
                                 got.glyph, got.fg, got.bg, got.coloured);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no transaction moves for too long
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else begin
            if (s_tvalid && !s_tready) begin
                input_stall_cycles <= input_stall_cycles + 1;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles, %0d cells pending",
                         idle_cycles, cell_expect_q.size());
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
